[rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// shared constants, controller states and the command/status bundles of the
// batch signal statistics block
// ----------------------------------------------------------------------------
package bss_pkg;

  // block geometry
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 24;

  // derived widths
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W     = $clog2(MAX_SAMPLES);
  localparam int SUM_W      = SAMPLE_BITS + CNT_W;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int VAR_W      = SQ_W + CNT_W;
  localparam int DIV_W      = VAR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int ROOT_W     = (DIV_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

  // fixed result widths
  localparam int STD_W   = 24;
  localparam int CROSS_W = 10;
  localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_VAR_START,
    S_VAR_WAIT,
    S_VDIV_START,
    S_VDIV_WAIT,
    S_SQRT_START,
    S_SQRT_WAIT,
    S_EMIT
  } state_e;

  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     var_start;
    logic     sqrt_start;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic var_done;
    logic sqrt_done;
    logic out_busy;
  } status_t;

endpackage

[rtl/bss_div.sv]
// ----------------------------------------------------------------------------
// bss_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bss_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bss_pkg::DIV_W-1:0]   dividend_i,
  input  logic [bss_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bss_pkg::DIV_W-1:0]   quotient_o
);
  import bss_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [CNT_W-1:0] rem_d;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - DIV_CNT_W'(1);
        done_q <= (cnt_q == DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/bss_isqrt.sv]
// ----------------------------------------------------------------------------
// bss_isqrt
// digit-by-digit floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module bss_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bss_pkg::DIV_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [bss_pkg::ROOT_W-1:0]  root_o
);
  import bss_pkg::*;

  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W+1:0]     rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic                  done_q;

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= ROOT_CNT_W'(ROOT_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - ROOT_CNT_W'(1);
        done_q <= (cnt_q == ROOT_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RAD_W'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/bss_datapath.sv]
// ----------------------------------------------------------------------------
// bss_datapath
// sample store, running accumulators, squared-deviation pass, shared divider,
// square root and the result register
// ----------------------------------------------------------------------------
module bss_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bss_pkg::cmd_t                         cmd_i,
  output bss_pkg::status_t                      status_o,
  input  logic signed [bss_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] mean_value_o,
  output logic        [bss_pkg::STD_W-1:0]      std_deviation_o,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] min_value_o,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] max_value_o,
  output logic        [bss_pkg::CROSS_W-1:0]    crossing_count_o,
  output logic        [bss_pkg::CNT_W-1:0]      sample_count_o,
  output logic                                  overflowed_o
);
  import bss_pkg::*;

  // running accumulators
  logic        [CNT_W-1:0]       count_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SAMPLE_BITS-1:0] min_q;
  logic signed [SAMPLE_BITS-1:0] max_q;
  logic        [CROSS_W-1:0]     cross_q;
  logic                          prev_neg_q;
  logic                          ovf_q;

  logic                          full;
  logic                          store_wr;
  logic                          neg;

  // sample store
  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

  // deviation pass
  logic        [CNT_W-1:0]       idx_q;
  logic        [CNT_W-1:0]       idx_nxt;
  logic                          issuing_q;
  logic                          v1_q, v2_q, v3_q;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic        [SAMPLE_BITS-1:0] absd_q;
  logic        [SAMPLE_BITS-1:0] absd_d;
  logic signed [SAMPLE_BITS:0]   diff;
  logic        [SQ_W-1:0]        sq_q;
  logic        [SQ_W-1:0]        sq_d;
  logic        [VAR_W-1:0]       acc_q;

  // mean, divider, root
  logic                          sum_neg;
  logic        [SUM_W-1:0]       sum_abs;
  logic        [DIV_W-1:0]       dividend;
  logic        [DIV_W-1:0]       div_quot;
  logic                          div_done;
  logic                          sqrt_done;
  logic        [ROOT_W-1:0]      root;
  logic        [SAMPLE_BITS-1:0] mean_mag;
  logic signed [SAMPLE_BITS-1:0] mean_d;
  logic signed [SAMPLE_BITS-1:0] mean_q;

  // result register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] res_mean_q, res_min_q, res_max_q;
  logic        [STD_W-1:0]       res_std_q;
  logic        [CROSS_W-1:0]     res_cross_q;
  logic        [CNT_W-1:0]       res_count_q;
  logic                          res_ovf_q;

  assign full     = (count_q == CNT_W'(MAX_SAMPLES));
  assign store_wr = cmd_i.load && !full;
  assign neg      = sample_i[SAMPLE_BITS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_q      <= '0;
      min_q      <= '0;
      max_q      <= '0;
      cross_q    <= '0;
      prev_neg_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.emit) begin
      count_q    <= '0;
      sum_q      <= '0;
      min_q      <= '0;
      max_q      <= '0;
      cross_q    <= '0;
      prev_neg_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        if (count_q == '0) begin
          min_q <= sample_i;
          max_q <= sample_i;
        end else begin
          if (sample_i < min_q) min_q <= sample_i;
          if (sample_i > max_q) max_q <= sample_i;
          if ((neg != prev_neg_q) && (cross_q != CROSS_MAX)) begin
            cross_q <= cross_q + CROSS_W'(1);
          end
        end
        prev_neg_q <= neg;
        sum_q      <= sum_q + SUM_W'(sample_i);
        count_q    <= count_q + CNT_W'(1);
      end
    end
  end

  // store write and pass read, read data registered
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      mem[count_q[ADDR_W-1:0]] <= sample_i;
    end
    if (issuing_q) begin
      rd_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  // squared deviation pipeline: read, abs difference, square, accumulate
  assign idx_nxt = idx_q + CNT_W'(1);
  assign diff    = {rd_q[SAMPLE_BITS-1], rd_q} - {mean_q[SAMPLE_BITS-1], mean_q};
  assign absd_d  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
  assign sq_d    = absd_q * absd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      issuing_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      v1_q <= issuing_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.var_start) begin
        idx_q     <= '0;
        issuing_q <= 1'b1;
      end else if (issuing_q) begin
        idx_q <= idx_nxt;
        if (idx_nxt == count_q) issuing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    absd_q <= absd_d;
    sq_q   <= sq_d;
    if (cmd_i.var_start) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + VAR_W'(sq_q);
    end
  end

  // shared divider: magnitude of the sum first, then the squared deviations
  assign sum_neg  = sum_q[SUM_W-1];
  assign sum_abs  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign dividend = (cmd_i.div_sel == DIV_MEAN) ? DIV_W'(sum_abs) : acc_q;

  bss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign mean_mag = div_quot[SAMPLE_BITS-1:0];
  assign mean_d   = sum_neg ? -signed'(mean_mag) : signed'(mean_mag);

  always_ff @(posedge clk_i) begin
    if (div_done && (cmd_i.div_sel == DIV_MEAN)) begin
      mean_q <= mean_d;
    end
  end

  bss_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (div_quot),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_mean_q  <= mean_q;
      res_std_q   <= STD_W'(root);
      res_min_q   <= min_q;
      res_max_q   <= max_q;
      res_cross_q <= cross_q;
      res_count_q <= count_q;
      res_ovf_q   <= ovf_q;
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.var_done  = !issuing_q && !v1_q && !v2_q && !v3_q;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign mean_value_o     = res_mean_q;
  assign std_deviation_o  = res_std_q;
  assign min_value_o      = res_min_q;
  assign max_value_o      = res_max_q;
  assign crossing_count_o = res_cross_q;
  assign sample_count_o   = res_count_q;
  assign overflowed_o     = res_ovf_q;

endmodule

[rtl/bss_ctrl.sv]
// ----------------------------------------------------------------------------
// bss_ctrl
// phase sequencer: collect, mean divide, deviation pass, variance divide,
// square root, result hand-off
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_sample_i,
  output logic             in_stall_o,
  output bss_pkg::cmd_t    cmd_o,
  input  bss_pkg::status_t status_i
);
  import bss_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_COLLECT: begin
        if (in_valid_i && last_sample_i) state_d = S_MEAN_START;
      end
      S_MEAN_START: state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (status_i.div_done) state_d = S_VAR_START;
      end
      S_VAR_START: state_d = S_VAR_WAIT;
      S_VAR_WAIT: begin
        if (status_i.var_done) state_d = S_VDIV_START;
      end
      S_VDIV_START: state_d = S_VDIV_WAIT;
      S_VDIV_WAIT: begin
        if (status_i.div_done) state_d = S_SQRT_START;
      end
      S_SQRT_START: state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (status_i.sqrt_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_busy) state_d = S_COLLECT;
      end
      default: state_d = S_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_COLLECT: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_MEAN_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
      end
      S_MEAN_WAIT: cmd_o.div_sel = DIV_MEAN;
      S_VAR_START: cmd_o.var_start = 1'b1;
      S_VDIV_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_VAR;
      end
      S_VDIV_WAIT: cmd_o.div_sel = DIV_VAR;
      S_SQRT_START: cmd_o.sqrt_start = 1'b1;
      S_EMIT: cmd_o.emit = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/batch_signal_statistics_top.sv]
// ----------------------------------------------------------------------------
// batch_signal_statistics_top
// block statistics over signed samples: mean, population standard deviation,
// minimum, maximum, zero crossings, sample count and overflow flag
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per sample (sample_i, last_sample_i), taken at an
//   edge with in_valid_i high and in_stall_o low; last_sample_i closes a block
//   output channel: one result beat per block, taken at an edge with
//   out_valid_o high and out_stall_i low
// timing
//   samples of a block are taken one per cycle while collecting
//   after the closing beat the input stalls through the compute phases: one
//   quotient bit per cycle in the shared divider (run twice, DIV_W = 59), one
//   pass over the N stored samples at one read per cycle, one root bit per
//   cycle (ROOT_W = 30)
// reset
//   clears the controller, the accumulators and the result valid; the sample
//   store is not cleared, only entries written in the current block are read
// back-pressure
//   the result sits in an output register; a new block can be collected while
//   it waits, and only the next hand-off stalls until the old beat is taken
// ----------------------------------------------------------------------------
module batch_signal_statistics_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample input
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [bss_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   last_sample_i,
  // result output
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] mean_value_o,
  output logic        [bss_pkg::STD_W-1:0]       std_deviation_o,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] min_value_o,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] max_value_o,
  output logic        [bss_pkg::CROSS_W-1:0]     crossing_count_o,
  output logic        [bss_pkg::CNT_W-1:0]       sample_count_o,
  output logic                                   overflowed_o
);
  import bss_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  bss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  bss_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mean_value_o     (mean_value_o),
    .std_deviation_o  (std_deviation_o),
    .min_value_o      (min_value_o),
    .max_value_o      (max_value_o),
    .crossing_count_o (crossing_count_o),
    .sample_count_o   (sample_count_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

[rtl/bss_checker.sv]
// ----------------------------------------------------------------------------
// bss_checker
// port-level checks of the batch signal statistics block, bound to the top
// ----------------------------------------------------------------------------
module bss_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   last_sample_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [bss_pkg::SAMPLE_BITS-1:0] mean_value_o,
  input logic        [bss_pkg::STD_W-1:0]       std_deviation_o,
  input logic signed [bss_pkg::SAMPLE_BITS-1:0] min_value_o,
  input logic signed [bss_pkg::SAMPLE_BITS-1:0] max_value_o,
  input logic        [bss_pkg::CNT_W-1:0]       sample_count_o
);
  import bss_pkg::*;

  // closing beat starts the compute phases, input must stall next
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_sample_i) |=> in_stall_o)
    else $error("input not stalled after closing beat");

  // a new result only appears out of a compute phase
  a_result_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while collecting");

  // result is never empty and its extremes are ordered
  a_count_and_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0) && (min_value_o <= max_value_o))
    else $error("bad count or min above max");

  // truncated mean stays within the extremes
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_value_o >= min_value_o) && (mean_value_o <= max_value_o))
    else $error("mean outside min and max");

  // stalled result beat holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(mean_value_o) && $stable(std_deviation_o)))
    else $error("stalled result changed");

endmodule

bind batch_signal_statistics_top bss_checker u_bss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_sample_i   (last_sample_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .mean_value_o    (mean_value_o),
  .std_deviation_o (std_deviation_o),
  .min_value_o     (min_value_o),
  .max_value_o     (max_value_o),
  .sample_count_o  (sample_count_o)
);
